// ===== hdl/slfa_pkg.sv =====
// Shared types, codes and constants of the slab free-list allocator.
`default_nettype none

package slfa_pkg;

    localparam int POOL_SLOTS_DEF = 256;
    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 17;
    localparam int CFG_IDX_W      = 1;
    localparam int STATUS_W       = 3;
    localparam int SLOT_OUT_W     = 8;
    localparam int FREE_OUT_W     = 9;
    localparam int COUNT_W        = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_SIZE = 1'd1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd65536;
    localparam logic [SIZE_W-1:0] SLAB_SIZE_RST = 17'd64;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd4;

    typedef struct packed {
        logic                clr_step;
        logic                in_load;
        logic                stk_rd;
        logic                acq_commit;
        logic                div_start;
        logic                held_rd;
        logic                rel_commit;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic depth_zero;
        logic depth_full;
        logic addr_null;
        logic addr_low;
        logic div_done;
        logic slot_over;
        logic slot_held;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/slfa_div.sv =====
// Restoring divider, one quotient bit per cycle, for address to slot conversion.
`default_nettype none

module slfa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [slfa_pkg::ADDR_W-1:0] dividend,
    input  wire logic [slfa_pkg::SIZE_W-1:0] divisor,
    output logic                            done,
    output logic [slfa_pkg::ADDR_W-1:0]     quotient
);
    import slfa_pkg::*;

    localparam int STEPS = ADDR_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;

    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top trial bit drops
            rem_next = fits ? trial[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quo_next = {quo_reg[ADDR_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/slfa_dpath.sv =====
// Allocator datapath: config registers, free stack, held map, divider and result register.
`default_nettype none

module slfa_dpath #(
    parameter int POOL_SLOTS = slfa_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire slfa_pkg::cmd_t                cmd,
    output slfa_pkg::sts_t                     sts,
    input  wire logic                          cfg_we,
    input  wire logic [slfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slfa_pkg::ADDR_W-1:0]   cfg_data,
    input  wire logic                          opcode,
    input  wire logic [slfa_pkg::ADDR_W-1:0]   slab_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               accepted,
    output logic [slfa_pkg::STATUS_W-1:0]      status,
    output logic [slfa_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [slfa_pkg::ADDR_W-1:0]        granted_address,
    output logic [slfa_pkg::FREE_OUT_W-1:0]    free_slots,
    output logic [slfa_pkg::COUNT_W-1:0]       acquired_total,
    output logic [slfa_pkg::COUNT_W-1:0]       released_total
);
    import slfa_pkg::*;

    localparam int SLOT_W  = $clog2(POOL_SLOTS);
    localparam int DEPTH_W = $clog2(POOL_SLOTS + 1);
    localparam int PROD_W  = SIZE_W + SLOT_W;
    localparam logic [SLOT_W-1:0]  SLOT_MAX   = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(POOL_SLOTS);
    localparam logic [ADDR_W-1:0]  SLOT_LIMIT = ADDR_W'(POOL_SLOTS);

    // configuration
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [SIZE_W-1:0]  slab_size_reg;

    // captured transaction
    logic               op_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // free stack and held map
    logic [SLOT_W-1:0]  stack_mem [POOL_SLOTS];
    logic               held_mem  [POOL_SLOTS];
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] min_depth_reg, min_depth_next;
    logic [SLOT_W-1:0]  stk_q_reg;
    logic [SLOT_W-1:0]  stk_dflt_reg;
    logic               stk_new_reg;
    logic               held_q_reg;
    logic [SLOT_W-1:0]  clr_cnt_reg;

    logic [DEPTH_W-1:0] depth_dec;
    logic [SLOT_W-1:0]  top_idx;
    logic [SLOT_W-1:0]  pop_slot;
    logic [SLOT_W-1:0]  rel_slot;
    logic               held_we;
    logic [SLOT_W-1:0]  held_wa;
    logic               held_wd;

    // arithmetic
    logic [ADDR_W-1:0]  div_q;
    logic               div_done;
    logic [PROD_W-1:0]  prod_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0] acq_cnt_reg;
    logic [COUNT_W-1:0] rel_cnt_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  res_ok_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic [FREE_OUT_W-1:0] res_free_reg;
    logic [COUNT_W-1:0]    res_acq_reg;
    logic [COUNT_W-1:0]    res_rel_reg;

    logic [31:0]        slot_ext;
    logic [31:0]        depth_ext;
    logic               res_ok;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign top_idx   = depth_dec[SLOT_W-1:0];
    // entries below the lowest depth reached were never overwritten
    assign pop_slot  = stk_new_reg ? stk_q_reg : stk_dflt_reg;
    assign rel_slot  = div_q[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RST;
            slab_size_reg <= SLAB_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE: pool_base_reg <= cfg_data;
                CFG_SLAB_SIZE: slab_size_reg <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg   <= opcode;
            addr_reg <= slab_address;
        end
    end

    slfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (addr_reg - pool_base_reg),
        .divisor  (slab_size_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        depth_next     = depth_reg;
        min_depth_next = min_depth_reg;
        if (cmd.acq_commit)
        begin
            depth_next = depth_dec;
            if (depth_dec < min_depth_reg)
            begin
                min_depth_next = depth_dec;
            end
        end
        else if (cmd.rel_commit)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= DEPTH_FULL;
            min_depth_reg <= DEPTH_FULL;
            clr_cnt_reg   <= '0;
            acq_cnt_reg   <= '0;
            rel_cnt_reg   <= '0;
        end
        else
        begin
            depth_reg     <= depth_next;
            min_depth_reg <= min_depth_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.acq_commit)
            begin
                acq_cnt_reg <= acq_cnt_reg + COUNT_W'(1);
            end
            if (cmd.rel_commit)
            begin
                rel_cnt_reg <= rel_cnt_reg + COUNT_W'(1);
            end
        end
    end

    // free stack: push on release, registered read of the top on acquire
    always_ff @(posedge clk)
    begin
        if (cmd.rel_commit)
        begin
            stack_mem[depth_reg[SLOT_W-1:0]] <= rel_slot;
        end
        if (cmd.stk_rd)
        begin
            stk_q_reg    <= stack_mem[top_idx];
            stk_dflt_reg <= SLOT_MAX - top_idx;
            stk_new_reg  <= depth_dec >= min_depth_reg;
        end
    end

    // held map: cleared after reset, set on acquire, cleared on release
    always_comb
    begin
        held_we = cmd.clr_step | cmd.acq_commit | cmd.rel_commit;
        held_wa = clr_cnt_reg;
        held_wd = 1'b0;
        if (cmd.acq_commit)
        begin
            held_wa = pop_slot;
            held_wd = 1'b1;
        end
        else if (cmd.rel_commit)
        begin
            held_wa = rel_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_wa] <= held_wd;
        end
        if (cmd.held_rd)
        begin
            held_q_reg <= held_mem[rel_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acq_commit)
        begin
            slot_reg <= pop_slot;
            prod_reg <= PROD_W'(slab_size_reg) * PROD_W'(pop_slot);
        end
        else if (cmd.rel_commit)
        begin
            slot_reg <= rel_slot;
        end
    end

    assign slot_ext  = 32'(slot_reg);
    assign depth_ext = 32'(depth_reg);
    assign res_ok    = cmd.out_status == ST_OK;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_ok_reg     <= res_ok;
            res_status_reg <= cmd.out_status;
            res_slot_reg   <= res_ok ? slot_ext[SLOT_OUT_W-1:0] : '0;
            res_addr_reg   <= (res_ok && !op_reg) ?
                              pool_base_reg + ADDR_W'(prod_reg) : '0;
            res_free_reg   <= depth_ext[FREE_OUT_W-1:0];
            res_acq_reg    <= acq_cnt_reg;
            res_rel_reg    <= rel_cnt_reg;
        end
    end

    always_comb
    begin
        sts.clr_done   = clr_cnt_reg == SLOT_MAX;
        sts.depth_zero = depth_reg == '0;
        sts.depth_full = depth_reg >= DEPTH_FULL;
        sts.addr_null  = addr_reg == '0;
        sts.addr_low   = (addr_reg < pool_base_reg) || (slab_size_reg == '0);
        sts.div_done   = div_done;
        sts.slot_over  = div_q >= SLOT_LIMIT;
        sts.slot_held  = held_q_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign accepted        = res_ok_reg;
    assign status          = res_status_reg;
    assign slot_index      = res_slot_reg;
    assign granted_address = res_addr_reg;
    assign free_slots      = res_free_reg;
    assign acquired_total  = res_acq_reg;
    assign released_total  = res_rel_reg;

endmodule

`default_nettype wire

// ===== hdl/slfa_ctrl.sv =====
// Allocator controller: sequences clearing, acquire and release transactions.
`default_nettype none

module slfa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           opcode,
    input  wire slfa_pkg::sts_t sts,
    output slfa_pkg::cmd_t      cmd
);
    import slfa_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ACQ_RD  = 4'd2;
    localparam logic [3:0] S_ACQ_WR  = 4'd3;
    localparam logic [3:0] S_REL_CHK = 4'd4;
    localparam logic [3:0] S_REL_DIV = 4'd5;
    localparam logic [3:0] S_REL_WR  = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.out_status = status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = opcode ? S_REL_CHK : S_ACQ_RD;
                end
            end
            S_ACQ_RD:
            begin
                if (sts.depth_zero)
                begin
                    status_next = ST_EXHAUSTED;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.stk_rd = 1'b1;
                    state_next = S_ACQ_WR;
                end
            end
            S_ACQ_WR:
            begin
                cmd.acq_commit = 1'b1;
                status_next    = ST_OK;
                state_next     = S_FIN;
            end
            S_REL_CHK:
            begin
                if (sts.addr_null)
                begin
                    status_next = ST_NULL;
                    state_next  = S_FIN;
                end
                else if (sts.addr_low)
                begin
                    status_next = ST_OUTSIDE;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_REL_DIV;
                end
            end
            S_REL_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.slot_over)
                    begin
                        status_next = ST_OUTSIDE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        cmd.held_rd = 1'b1;
                        state_next  = S_REL_WR;
                    end
                end
            end
            S_REL_WR:
            begin
                if (!sts.slot_held || sts.depth_full)
                begin
                    status_next = ST_NOT_HELD;
                end
                else
                begin
                    cmd.rel_commit = 1'b1;
                    status_next    = ST_OK;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slab_free_list_allocator.sv =====
// Slab allocator top level: LIFO free list of slots with held-slot checking.
// An acquire reads the top of the free stack, then commits it; when the list is exhausted it
//   ends at once. A release ends at once on a null or low address; else the 32-step restoring
//   divider runs and it ends past the pool, or reads the held map, then commits or refuses.
// One transaction at a time; the next can be taken in the cycle after the result loads.
// Reset: all slots free, slot 0 on top; no input is taken while the held map is cleared.
`default_nettype none

module slab_free_list_allocator #(
    parameter int POOL_SLOTS = slfa_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [slfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slfa_pkg::ADDR_W-1:0]    cfg_data,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic [slfa_pkg::ADDR_W-1:0]    slab_address,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                accepted,
    output logic [slfa_pkg::STATUS_W-1:0]       status,
    output logic [slfa_pkg::SLOT_OUT_W-1:0]     slot_index,
    output logic [slfa_pkg::ADDR_W-1:0]         granted_address,
    output logic [slfa_pkg::FREE_OUT_W-1:0]     free_slots,
    output logic [slfa_pkg::COUNT_W-1:0]        acquired_total,
    output logic [slfa_pkg::COUNT_W-1:0]        released_total
);
    import slfa_pkg::*;

    // command and status bundles between controller and datapath
    cmd_t cmd;
    sts_t sts;

    // Controller: walks each transaction through its steps, holds the input
    // channel while busy, and waits on the result register only at the end,
    // so a new transaction can be taken while a result is still pending.
    slfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: configuration, free stack, held map, divider, multiplier for
    // the granted address, running totals and the result register.
    slfa_dpath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .slab_address    (slab_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .status          (status),
        .slot_index      (slot_index),
        .granted_address (granted_address),
        .free_slots      (free_slots),
        .acquired_total  (acquired_total),
        .released_total  (released_total)
    );

endmodule

`default_nettype wire

// ===== dv/slfa_tb_pkg.sv =====
// Request codes shared by the allocator testbench's stimulus and result checker.
package slfa_tb_pkg;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } slab_op_e;

endpackage

// ===== dv/slfa_result_checker.sv =====
// Result checker: predicts every allocator outcome and compares it with the block's result.
module slfa_result_checker
    import slfa_pkg::*;
    import slfa_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  opcode,
    input  logic [ADDR_W-1:0]     slab_address,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  accepted,
    input  logic [STATUS_W-1:0]   status,
    input  logic [SLOT_OUT_W-1:0] slot_index,
    input  logic [ADDR_W-1:0]     granted_address,
    input  logic [FREE_OUT_W-1:0] free_slots,
    input  logic [COUNT_W-1:0]    acquired_total,
    input  logic [COUNT_W-1:0]    released_total,
    output int unsigned           mismatch_count,
    output int unsigned           pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                  ok;
        logic [STATUS_W-1:0]   code;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     addr;
        logic [FREE_OUT_W-1:0] free;
        logic [COUNT_W-1:0]    acq_total;
        logic [COUNT_W-1:0]    rel_total;
    } outcome_t;

    // predicted allocator state
    logic [7:0]         free_stack [POOL_SLOTS_DEF];
    logic [8:0]         free_depth;
    logic               slot_taken [POOL_SLOTS_DEF];
    logic [COUNT_W-1:0] acquires;
    logic [COUNT_W-1:0] releases;
    logic [ADDR_W-1:0]  pool_base;
    logic [SIZE_W-1:0]  slab_size;

    outcome_t expected_outcomes [$];

    function automatic outcome_t allocate_or_release(input slab_op_e op,
                                                     input logic [ADDR_W-1:0] addr);
        outcome_t          r;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] slot_no;
        logic [7:0]        slot;
        r = '0;
        if (op == OP_ACQUIRE) begin
            if (free_depth == '0) begin
                r.code = ST_EXHAUSTED;
            end else begin
                free_depth       = free_depth - 9'd1;
                slot             = free_stack[free_depth[7:0]];
                slot_taken[slot] = 1'b1;
                acquires         = acquires + 1;
                r.ok   = 1'b1;
                r.code = ST_OK;
                r.slot = slot;
                r.addr = pool_base + ADDR_W'(slab_size) * ADDR_W'(slot);
            end
        end else if (addr == '0) begin
            r.code = ST_NULL;
        end else if (addr < pool_base || slab_size == '0) begin
            r.code = ST_OUTSIDE;
        end else begin
            offset  = addr - pool_base;
            slot_no = offset / ADDR_W'(slab_size);
            if (slot_no >= POOL_SLOTS_DEF) begin
                r.code = ST_OUTSIDE;
            end else if (!slot_taken[slot_no[7:0]] || free_depth >= POOL_SLOTS_DEF) begin
                r.code = ST_NOT_HELD;
            end else begin
                slot                         = slot_no[7:0];
                slot_taken[slot]             = 1'b0;
                free_stack[free_depth[7:0]]  = slot;
                free_depth                   = free_depth + 9'd1;
                releases                     = releases + 1;
                r.ok   = 1'b1;
                r.code = ST_OK;
                r.slot = slot;
            end
        end
        r.free      = free_depth;
        r.acq_total = acquires;
        r.rel_total = releases;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t want;
        outcome_t got;
        int       k;
        int       bad;
        if (!rst_n) begin
            for (k = 0; k < POOL_SLOTS_DEF; k++) begin
                free_stack[k] = 8'(POOL_SLOTS_DEF - 1 - k);
                slot_taken[k] = 1'b0;
            end
            free_depth = 9'(POOL_SLOTS_DEF);
            acquires   = '0;
            releases   = '0;
            pool_base  = POOL_BASE_RST;
            slab_size  = SLAB_SIZE_RST;
            expected_outcomes.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
        end else begin
            // compare before predicting: a result leaving now belongs to an older request
            if (out_valid && !out_stall) begin
                got = '{accepted, status, slot_index, granted_address, free_slots,
                        acquired_total, released_total};
                if (expected_outcomes.size() == 0) begin
                    $error("result with no request outstanding: status 0x%0h", status);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_outcomes.pop_front();
                    bad  = field_differs("accepted", want.ok, got.ok)
                         + field_differs("status", want.code, got.code)
                         + field_differs("slot_index", want.slot, got.slot)
                         + field_differs("granted_address", want.addr, got.addr)
                         + field_differs("free_slots", want.free, got.free)
                         + field_differs("acquired_total", want.acq_total, got.acq_total)
                         + field_differs("released_total", want.rel_total, got.rel_total);
                    if (bad != 0)
                        mismatch_count <= mismatch_count + 1;
                end
            end
            if (in_valid && !in_stall)
                expected_outcomes.push_back(allocate_or_release(slab_op_e'(opcode),
                                                                slab_address));
            if (cfg_we) begin
                if (cfg_index == CFG_POOL_BASE)
                    pool_base = cfg_data;
                else if (cfg_index == CFG_SLAB_SIZE)
                    slab_size = cfg_data[SIZE_W-1:0];
            end
            pending_results <= expected_outcomes.size();
        end
    end

endmodule

// ===== dv/tb_slab_free_list_allocator.sv =====
// Testbench top for the slab free-list allocator: stimulus, idling and verdict.
module tb_slab_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import slfa_pkg::*;
    import slfa_tb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off to back the block up
    localparam int SETTLE_CYCLES   = 50;    // above the slowest release latency
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SLOT_IDX_W      = $clog2(POOL_SLOTS_DEF);

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_POOL_BASE;
    logic [ADDR_W-1:0]     cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  opcode       = OP_ACQUIRE;
    logic [ADDR_W-1:0]     slab_address = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  accepted;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ADDR_W-1:0]     granted_address;
    logic [FREE_OUT_W-1:0] free_slots;
    logic [COUNT_W-1:0]    acquired_total;
    logic [COUNT_W-1:0]    released_total;

    int unsigned mismatches;
    int unsigned pending;

    // idling knobs, set per phase by the stimulus process
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit squeeze_on         = 1'b0;
    bit squeeze_done       = 1'b0;

    // stimulus view of the configuration and of which slots are out on loan
    logic [ADDR_W-1:0] cur_base = POOL_BASE_RST;
    logic [SIZE_W-1:0] cur_size = SLAB_SIZE_RST;
    bit                slot_held [POOL_SLOTS_DEF];
    slab_op_e          op_log [$];

    always #6 clk = ~clk;

    slab_free_list_allocator i_dut (.*);

    slfa_result_checker i_checker (
        .*,
        .mismatch_count  (mismatches),
        .pending_results (pending)
    );

    // Track granted slots from the results so releases can target held slabs.
    always @(posedge clk)
    begin : track_loans
        slab_op_e op;
        if (out_valid && !out_stall && op_log.size() > 0)
        begin
            op = op_log.pop_front();
            if (accepted)
                slot_held[slot_index] = (op == OP_ACQUIRE);
        end
        if (in_valid && !in_stall)
            op_log.push_back(slab_op_e'(opcode));
    end

    // Receiver: random stalls per phase, plus one long hold-off when a phase asks for it.
    initial
    begin : receiver
        int k;
        forever
        begin
            @(posedge clk);
            if (squeeze_on && !squeeze_done)
            begin
                // hold the result channel shut while the sender keeps offering
                for (k = 0; k < HOLD_OFF_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                squeeze_done = 1'b1;
            end
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Offer one transaction after a random gap; return at the edge that takes it.
    task automatic offer(input slab_op_e op, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        slab_address <= addr;
        do @(posedge clk); while (in_stall);
    endtask

    // Address of a slab under the current settings, at its start or somewhere inside.
    function automatic logic [ADDR_W-1:0] slab_addr(input int slot, input bit exact);
        logic [ADDR_W-1:0] a;
        a = cur_base + ADDR_W'(cur_size) * ADDR_W'(slot);
        if (!exact && cur_size > 1)
            a = a + $urandom_range(0, cur_size - 1);
        return a;
    endfunction

    function automatic int held_slot();
        int start;
        int k;
        int idx;
        start = $urandom_range(0, POOL_SLOTS_DEF - 1);
        for (k = 0; k < POOL_SLOTS_DEF; k++)
        begin
            idx = (start + k) % POOL_SLOTS_DEF;
            if (slot_held[idx[SLOT_IDX_W-1:0]])
                return idx;
        end
        return -1;
    endfunction

    // Mostly well-formed acquire/release traffic, with null, stray and out-of-pool noise.
    task automatic random_item(input int acq_pct);
        int                pick;
        int                slot;
        logic [ADDR_W-1:0] a;
        if ($urandom_range(0, 99) < acq_pct)
        begin
            offer(OP_ACQUIRE, $urandom());
        end
        else
        begin
            pick = $urandom_range(0, 99);
            slot = held_slot();
            if (pick < 65 && slot >= 0)
                a = slab_addr(slot, 1'($urandom_range(0, 1)));
            else if (pick < 72)
                a = '0;
            else if (pick < 80)
                a = $urandom();
            else if (pick < 87 && cur_base > 1)
                a = $urandom_range(1, cur_base - 1);
            else if (pick < 94)
                a = slab_addr($urandom_range(0, POOL_SLOTS_DEF - 1), 1'b0);
            else
                a = slab_addr(POOL_SLOTS_DEF + $urandom_range(0, 3), 1'b0);
            offer(OP_RELEASE, a);
        end
    endtask

    // Drop valid and wait until every result is home, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                             input int idle_pct, input int stall_pct, input int acq_pct,
                             input int count, input bit squeeze);
        int n;
        settle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_SLAB_SIZE, ADDR_W'(size));
        cfg_we             <= 1'b0;
        cur_base           = base;
        cur_size           = size;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        squeeze_on         = squeeze;
        for (n = 0; n < count; n++)
            random_item(acq_pct);
    endtask

    initial
    begin : stimulus
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed transactions at the reset settings (base 65536, 64-byte slabs).
        offer(OP_ACQUIRE, 32'h0000_0000);                       // slot 0
        offer(OP_ACQUIRE, 32'hFFFF_FFFF);                       // slot 1, address ignored
        offer(OP_RELEASE, 32'h0000_0000);                       // null address
        offer(OP_RELEASE, POOL_BASE_RST - 1);                   // just below the base
        offer(OP_RELEASE, 32'h0000_0001);                       // far below the base
        offer(OP_RELEASE, POOL_BASE_RST + 32'd64 * 256);        // one past the pool
        offer(OP_RELEASE, 32'hFFFF_FFFF);                       // slot far beyond the pool
        offer(OP_RELEASE, POOL_BASE_RST + 32'd64 + 32'd63);     // slot 1, last byte
        offer(OP_RELEASE, POOL_BASE_RST + 32'd64);              // slot 1 again: double release
        offer(OP_RELEASE, POOL_BASE_RST + 32'd64 * 255 + 63);   // never granted
        offer(OP_ACQUIRE, 32'h0000_0000);                       // slot 1 comes back off the top
        offer(OP_RELEASE, POOL_BASE_RST);                       // slot 0 at its start
        offer(OP_RELEASE, POOL_BASE_RST + 32'd64);              // slot 1

        // Random phases: base, size, sender idle %, receiver stall %, acquire %, count, squeeze.
        run_phase(POOL_BASE_RST, SLAB_SIZE_RST, 0, 0, 60, 200, 1'b0);
        // heavy acquiring drains the free list into exhaustion
        run_phase(32'h0000_0001, 17'd1, 51, 0, 95, 260, 1'b0);
        // top base, 65536-byte slabs: granted addresses wrap past 2^32
        run_phase(32'hFFFF_FFFF, 17'd65536, 0, 51, 40, 220, 1'b0);
        // zero slab size: every slot maps to the base and releases bounce
        run_phase($urandom(), 17'd0, 0, 0, 50, 200, 1'b0);
        // all-ones size field, mostly releases to refill the list
        run_phase(32'h1000_0000, 17'h1FFFF, 18, 18, 25, 240, 1'b0);
        // long receiver hold-off while the sender keeps pushing
        run_phase($urandom_range(1, 32'h7FFF_FFFF), SIZE_W'($urandom_range(1, 65536)), 0, 51,
                  55, 240, 1'b1);
        run_phase($urandom_range(1, 32'h00FF_FFFF), SIZE_W'($urandom_range(1, 4096)), 18, 18,
                  50, 230, 1'b0);

        // Drain, bounded, then give the block time to show any stray result.
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/slfa_pkg.sv
hdl/slfa_div.sv
hdl/slfa_dpath.sv
hdl/slfa_ctrl.sv
hdl/slab_free_list_allocator.sv
dv/slfa_tb_pkg.sv
dv/slfa_result_checker.sv
dv/tb_slab_free_list_allocator.sv
